FILE: hw/rtl/hcbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbc_pkg
// Shared constants, register codes and pixel window helpers for the
// colour blob centroid block.
// ----------------------------------------------------------------------------
package hcbc_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int FIFO_DEPTH     = 2;

  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int IN_TDATA_W = 3 * PIX_W;

  localparam logic [CFG_DATA_W-1:0] LINE_WIDTH_RST = 11'd640;
  localparam logic [PIX_W:0]        HUE_MOD        = 9'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUE_CENTER    = 3'd0,
    REG_HUE_TOLERANCE = 3'd1,
    REG_SAT_CENTER    = 3'd2,
    REG_SAT_TOLERANCE = 3'd3,
    REG_VAL_CENTER    = 3'd4,
    REG_VAL_TOLERANCE = 3'd5,
    REG_LINE_WIDTH    = 3'd6
  } cfg_reg_t;

  // value in [0, 2*255] reduced modulo 255
  function automatic logic [PIX_W-1:0] mod_hue(input logic [PIX_W:0] x);
    logic [PIX_W:0] r;
    if (x >= {HUE_MOD[PIX_W-1:0], 1'b0}) begin
      r = x - {HUE_MOD[PIX_W-1:0], 1'b0};
    end else if (x >= HUE_MOD) begin
      r = x - HUE_MOD;
    end else begin
      r = x;
    end
    return r[PIX_W-1:0];
  endfunction

  function automatic logic hue_match(input logic [PIX_W-1:0] centre,
                                     input logic [PIX_W-1:0] h,
                                     input logic [PIX_W-1:0] tol);
    logic [PIX_W-1:0] d1;
    logic [PIX_W-1:0] d2;
    d1 = mod_hue({1'b0, centre} + HUE_MOD - {1'b0, h});
    d2 = mod_hue({1'b0, h} + HUE_MOD - {1'b0, centre});
    return (d1 <= tol) || (d2 <= tol);
  endfunction

  function automatic logic in_window(input logic [PIX_W-1:0] x,
                                     input logic [PIX_W-1:0] centre,
                                     input logic [PIX_W-1:0] tol);
    logic signed [PIX_W+1:0] lo;
    logic signed [PIX_W+1:0] hi;
    logic signed [PIX_W+1:0] xs;
    lo = $signed({2'b00, centre}) - $signed({2'b00, tol});
    hi = $signed({2'b00, centre}) + $signed({2'b00, tol});
    xs = $signed({2'b00, x});
    return (xs >= lo) && (xs <= hi);
  endfunction

endpackage

FILE: hw/rtl/hsv_color_blob_centroid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_color_blob_centroid
// HSV colour window classifier with per-frame centroid of matching pixels.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata / payload (lsb first)             | marker
//  s_axis   | in        | hue, saturation, brightness             | tlast = frame_end
//  m_axis   | out       | is_target, centroid_x, centroid_y,      | tlast = centroid_valid
//           |           | pixel_count                             |
//  cfg      | in        | cfg_index, cfg_data                     | always ready
//
//  one pixel per cycle through the front end while the queue has room; each
//  mid-frame result is registered and appears on m_axis in the cycle after its
//  pixel enters the back end; a frame's last pixel holds the back end while the
//  serial divider runs (one quotient bit per cycle for each mean); the two-entry
//  queue lets the front keep taking pixels meanwhile until both entries are full
//  rst is synchronous; no clearing pass, ready right after reset
// ----------------------------------------------------------------------------
module hsv_color_blob_centroid
  import hcbc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int CNT_W       = 2 * COORD_BITS + 1,
  localparam int OUT_USED    = 1 + 2 * COORD_BITS + CNT_W,
  localparam int OUT_TDATA_W = ((OUT_USED + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // hue, saturation, brightness
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // is_target, centroid_x, centroid_y, pixel_count
  output logic                   m_axis_tlast
);

  localparam int SUM_W = 3 * COORD_BITS;
  localparam int Q_W   = 2 + CNT_W + 2 * SUM_W;

  logic                  fq_valid;
  logic                  fq_ready;
  logic [Q_W-1:0]        fq_data;
  logic                  qb_valid;
  logic                  qb_ready;
  logic [Q_W-1:0]        qb_data;
  logic                  res_target;
  logic [COORD_BITS-1:0] res_x;
  logic [COORD_BITS-1:0] res_y;
  logic [CNT_W-1:0]      res_count;

  hcbc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_valid  (s_axis_tvalid),
    .pix_ready  (s_axis_tready),
    .hue        (s_axis_tdata[PIX_W-1:0]),
    .saturation (s_axis_tdata[2*PIX_W-1:PIX_W]),
    .brightness (s_axis_tdata[3*PIX_W-1:2*PIX_W]),
    .frame_end  (s_axis_tlast),
    .q_valid    (fq_valid),
    .q_ready    (fq_ready),
    .q_data     (fq_data)
  );

  hcbc_fifo #(.WIDTH(Q_W), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  hcbc_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (qb_valid),
    .q_ready       (qb_ready),
    .q_data        (qb_data),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_is_target (res_target),
    .out_last      (m_axis_tlast),
    .out_x         (res_x),
    .out_y         (res_y),
    .out_count     (res_count)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_USED){1'b0}}, res_count, res_y, res_x, res_target};

endmodule

FILE: hw/rtl/hcbc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbc_fifo
// Small register queue between the pixel front end and the centroid back end.
// ----------------------------------------------------------------------------
module hcbc_fifo
  import hcbc_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push;
  logic             pop;

  assign wr_ready = (fill != CNT_W'(DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/hcbc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbc_front
// Configuration registers, colour window test, raster position tracking and
// coordinate accumulation; one queue entry per pixel.
// ----------------------------------------------------------------------------
module hcbc_front
  import hcbc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int SUM_W = 3 * COORD_BITS,
  localparam int CNT_W = 2 * COORD_BITS + 1,
  localparam int Q_W   = 2 + CNT_W + 2 * SUM_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  pix_valid,
  output logic                  pix_ready,
  input  logic [PIX_W-1:0]      hue,
  input  logic [PIX_W-1:0]      saturation,
  input  logic [PIX_W-1:0]      brightness,
  input  logic                  frame_end,
  output logic                  q_valid,
  input  logic                  q_ready,
  output logic [Q_W-1:0]        q_data
);

  localparam int CB = COORD_BITS;

  logic [PIX_W-1:0]      hue_center;
  logic [PIX_W-1:0]      hue_tolerance;
  logic [PIX_W-1:0]      sat_center;
  logic [PIX_W-1:0]      sat_tolerance;
  logic [PIX_W-1:0]      val_center;
  logic [PIX_W-1:0]      val_tolerance;
  logic [CFG_DATA_W-1:0] line_width;

  logic [CB-1:0]    column_counter;
  logic [CB-1:0]    row_counter;
  logic [SUM_W-1:0] column_sum;
  logic [SUM_W-1:0] row_sum;
  logic [CNT_W-1:0] match_count;

  logic [CB:0]      width_eff;
  logic             wrap_pre;
  logic [CB-1:0]    col_eff;
  logic [CB-1:0]    row_eff;
  logic [CB:0]      col_inc;
  logic             hit;
  logic             acc;
  logic [SUM_W-1:0] column_sum_next;
  logic [SUM_W-1:0] row_sum_next;
  logic [CNT_W-1:0] match_count_next;
  logic             accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_center    <= '0;
      hue_tolerance <= '0;
      sat_center    <= '0;
      sat_tolerance <= '0;
      val_center    <= '0;
      val_tolerance <= '0;
      line_width    <= LINE_WIDTH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HUE_CENTER:    hue_center    <= cfg_data[PIX_W-1:0];
        REG_HUE_TOLERANCE: hue_tolerance <= cfg_data[PIX_W-1:0];
        REG_SAT_CENTER:    sat_center    <= cfg_data[PIX_W-1:0];
        REG_SAT_TOLERANCE: sat_tolerance <= cfg_data[PIX_W-1:0];
        REG_VAL_CENTER:    val_center    <= cfg_data[PIX_W-1:0];
        REG_VAL_TOLERANCE: val_tolerance <= cfg_data[PIX_W-1:0];
        REG_LINE_WIDTH:    line_width    <= cfg_data;
        default: ;
      endcase
    end
  end

  // line width clamped to 1 .. 2^COORD_BITS
  always_comb begin
    if (line_width == '0) begin
      width_eff = (CB+1)'(1);
    end else if (32'(line_width) > (32'd1 << CB)) begin
      width_eff = {1'b1, {CB{1'b0}}};
    end else begin
      width_eff = (CB+1)'(line_width);
    end
  end

  always_comb begin
    wrap_pre = ({1'b0, column_counter} >= width_eff);
    col_eff  = wrap_pre ? '0 : column_counter;
    row_eff  = wrap_pre ? row_counter + 1'b1 : row_counter;
    col_inc  = {1'b0, col_eff} + 1'b1;
    hit      = hue_match(hue_center, hue, hue_tolerance) &&
               in_window(saturation, sat_center, sat_tolerance) &&
               in_window(brightness, val_center, val_tolerance);
    acc      = hit && !match_count[CNT_W-1];
    column_sum_next  = acc ? column_sum + {{(SUM_W-CB){1'b0}}, col_eff} : column_sum;
    row_sum_next     = acc ? row_sum + {{(SUM_W-CB){1'b0}}, row_eff} : row_sum;
    match_count_next = acc ? match_count + 1'b1 : match_count;
  end

  assign pix_ready = q_ready;
  assign q_valid   = pix_valid;
  assign accept    = pix_valid && q_ready;
  assign q_data    = {hit, frame_end, match_count_next, row_sum_next, column_sum_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter    <= '0;
      column_sum     <= '0;
      row_sum        <= '0;
      match_count    <= '0;
    end else if (accept) begin
      if (frame_end) begin
        column_counter <= '0;
        row_counter    <= '0;
        column_sum     <= '0;
        row_sum        <= '0;
        match_count    <= '0;
      end else begin
        column_sum  <= column_sum_next;
        row_sum     <= row_sum_next;
        match_count <= match_count_next;
        if (col_inc >= width_eff) begin
          column_counter <= '0;
          row_counter    <= row_eff + 1'b1;
        end else begin
          column_counter <= col_inc[CB-1:0];
          row_counter    <= row_eff;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/hcbc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbc_back
// Result stage: passes mask bits through and runs a bit-serial restoring
// divider for the two centroid means at frame end.
// ----------------------------------------------------------------------------
module hcbc_back
  import hcbc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int SUM_W = 3 * COORD_BITS,
  localparam int CNT_W = 2 * COORD_BITS + 1,
  localparam int Q_W   = 2 + CNT_W + 2 * SUM_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic [Q_W-1:0]        q_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_is_target,
  output logic                  out_last,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic [CNT_W-1:0]      out_count
);

  localparam int CB     = COORD_BITS;
  localparam int STEP_W = $clog2(COORD_BITS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } back_state_t;

  back_state_t      state;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0] divisor;
  logic [CNT_W-1:0] rem_x;
  logic [CNT_W-1:0] rem_y;
  logic [CB-1:0]    quo_x;
  logic [CB-1:0]    quo_y;
  logic             hold_target;

  logic             e_target;
  logic             e_last;
  logic [CNT_W-1:0] e_count;
  logic [SUM_W-1:0] e_row_sum;
  logic [SUM_W-1:0] e_col_sum;
  logic             out_free;
  logic             out_load;
  logic [CNT_W:0]   trial_x;
  logic [CNT_W:0]   trial_y;
  logic             take_x;
  logic             take_y;

  assign {e_target, e_last, e_count, e_row_sum, e_col_sum} = q_data;
  assign out_free = !out_valid || out_ready;
  assign q_ready  = (state == ST_IDLE) && out_free;
  assign out_load = ((state == ST_IDLE) && q_valid && out_free && !e_last) ||
                    ((state == ST_HOLD) && out_free);

  always_comb begin
    trial_x = {rem_x, quo_x[CB-1]};
    trial_y = {rem_y, quo_y[CB-1]};
    take_x  = trial_x >= {1'b0, divisor};
    take_y  = trial_y >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid && out_free && e_last) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step == '0) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          if (e_last) begin
            divisor     <= e_count;
            rem_x       <= {1'b0, e_col_sum[SUM_W-1:CB]};
            rem_y       <= {1'b0, e_row_sum[SUM_W-1:CB]};
            quo_x       <= e_col_sum[CB-1:0];
            quo_y       <= e_row_sum[CB-1:0];
            hold_target <= e_target;
            step        <= STEP_W'(CB - 1);
          end else begin
            out_is_target <= e_target;
            out_last      <= 1'b0;
            out_x         <= '0;
            out_y         <= '0;
            out_count     <= '0;
          end
        end
      end
      ST_DIV: begin
        rem_x <= take_x ? CNT_W'(trial_x - {1'b0, divisor}) : trial_x[CNT_W-1:0];
        rem_y <= take_y ? CNT_W'(trial_y - {1'b0, divisor}) : trial_y[CNT_W-1:0];
        quo_x <= {quo_x[CB-2:0], take_x};
        quo_y <= {quo_y[CB-2:0], take_y};
        step  <= step - 1'b1;
      end
      ST_HOLD: begin
        if (out_free) begin
          out_is_target <= hold_target;
          out_last      <= 1'b1;
          out_x         <= (divisor == '0) ? '0 : quo_x;
          out_y         <= (divisor == '0) ? '0 : quo_y;
          out_count     <= divisor;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/hcbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbc_checker
// Port-level checks on the result stream of the centroid block.
// ----------------------------------------------------------------------------
module hcbc_checker
  import hcbc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int CNT_W       = 2 * COORD_BITS + 1,
  localparam int OUT_USED    = 1 + 2 * COORD_BITS + CNT_W,
  localparam int OUT_TDATA_W = ((OUT_USED + 7) / 8) * 8
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  localparam int CB = COORD_BITS;

  logic [CB-1:0]    chk_x;
  logic [CB-1:0]    chk_y;
  logic [CNT_W-1:0] chk_count;

  assign chk_x     = m_axis_tdata[CB:1];
  assign chk_y     = m_axis_tdata[2*CB:CB+1];
  assign chk_count = m_axis_tdata[OUT_USED-1:2*CB+1];

  // stalled transfer holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // mid-frame results carry only the mask bit
  a_mid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[OUT_TDATA_W-1:1] == '0)
    else $error("centroid fields set on mid-frame result");

  // empty frame gives a zero centroid
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast && chk_count == '0 |-> chk_x == '0 && chk_y == '0)
    else $error("non-zero centroid for empty frame");

  // count saturates at 2^(2*COORD_BITS)
  a_cap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |->
      !(chk_count[CNT_W-1] && (chk_count[CNT_W-2:0] != '0)))
    else $error("pixel count above limit");

  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind hsv_color_blob_centroid hcbc_checker #(.COORD_BITS(COORD_BITS)) u_hcbc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
